// ===== hw/rtl/lsbe_pkg.sv =====
// Package: shared constants and types for the LSB text embedder.
`timescale 1ns / 1ps
`default_nettype none

package lsbe_pkg;

   // Capacity of the message store in bytes (1 .. 4096)
   localparam int MaxMessageBytes = 256;

   localparam int LenWidth    = $clog2(MaxMessageBytes + 1);
   localparam int AddrWidth   = (MaxMessageBytes > 1) ? $clog2(MaxMessageBytes) : 1;
   // bit position runs up to (length + 1) * 8 inclusive
   localparam int BitPosWidth = $clog2((MaxMessageBytes + 1) * 8 + 1);
   localparam int IdxWidth    = BitPosWidth - 3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] LSB_CLEAR    = 8'hFE;
   localparam logic [7:0] TERMINATOR   = 8'h00;

   // Per-pixel embedding plan, worked out when the pixel is accepted
   typedef struct packed {
      logic [1:0] bit_count;   // message bits going into this pixel
      logic [2:0] bit_offset;  // first bit within the current byte, 0 = MSB
      logic       byte0_valid; // current byte lies below the message length
      logic       byte1_valid; // following byte lies below the message length
      logic       done;        // message and terminator used up after this pixel
      logic       overflow;    // bytes were dropped
   } plan_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lsbe_msg_ctrl.sv =====
// Message store, length / bit position state and per-pixel plan register.
`timescale 1ns / 1ps
`default_nettype none

module lsbe_msg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load_acc,
   input  wire logic                 pixel_acc,
   input  wire logic [7:0]           message_byte,
   input  wire logic                 message_first,
   output      lsbe_pkg::plan_type   plan,
   output      logic [7:0]           byte0,
   output      logic [7:0]           byte1
);

   localparam int LW = lsbe_pkg::LenWidth;
   localparam int AW = lsbe_pkg::AddrWidth;
   localparam int BW = lsbe_pkg::BitPosWidth;
   localparam int IW = lsbe_pkg::IdxWidth;
   localparam int Max = lsbe_pkg::MaxMessageBytes;

   logic [7:0] store_mem [Max];

   logic [LW-1:0] len_ff, len_in;
   logic [BW-1:0] bit_pos_ff, bit_pos_in;
   logic          ovf_ff, ovf_in;
   lsbe_pkg::plan_type plan_ff, plan_in;
   logic [7:0] rd0_ff, rd1_ff;

   logic [LW-1:0] len_eff;
   logic          full;
   logic [BW-1:0] total, remaining;
   logic [1:0]    count;
   logic [IW-1:0] idx, idx_next;
   logic [AW-1:0] rd0_addr, rd1_addr, wr_addr;

   always_comb begin
      len_eff   = message_first ? '0 : len_ff;
      full      = (len_eff == LW'(Max));
      wr_addr   = len_eff[AW-1:0];

      total     = (BW'(len_ff) << 3) + BW'(8);
      remaining = total - bit_pos_ff;
      count     = (remaining >= BW'(3)) ? 2'd3 : remaining[1:0];
      idx       = bit_pos_ff[BW-1:3];
      idx_next  = idx + IW'(1);
      rd0_addr  = idx[AW-1:0];
      rd1_addr  = idx_next[AW-1:0];

      plan_in.bit_count   = count;
      plan_in.bit_offset  = bit_pos_ff[2:0];
      plan_in.byte0_valid = (BW'(idx) < BW'(len_ff));
      plan_in.byte1_valid = (BW'(idx_next) < BW'(len_ff));
      plan_in.done        = (remaining <= BW'(3));
      plan_in.overflow    = ovf_ff;

      len_in     = len_ff;
      bit_pos_in = bit_pos_ff;
      ovf_in     = ovf_ff;
      if (load_acc) begin
         len_in     = full ? len_eff : len_eff + LW'(1);
         bit_pos_in = message_first ? '0 : bit_pos_ff;
         ovf_in     = (message_first ? 1'b0 : ovf_ff) | full;
      end else if (pixel_acc) begin
         bit_pos_in = bit_pos_ff + BW'(count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         bit_pos_ff <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         len_ff     <= len_in;
         bit_pos_ff <= bit_pos_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && !full) begin
         store_mem[wr_addr] <= message_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_acc) begin
         rd0_ff  <= store_mem[rd0_addr];
         rd1_ff  <= store_mem[rd1_addr];
         plan_ff <= plan_in;
      end
   end

   assign plan  = plan_ff;
   assign byte0 = rd0_ff;
   assign byte1 = rd1_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff <= total)
      else $error("bit position beyond message end");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(Max))
      else $error("message length beyond capacity");

   a_full_pixel: assert property (@(posedge clock) disable iff (reset)
      pixel_acc && remaining > BW'(3) |=> plan_ff.bit_count == 2'd3 && !plan_ff.done)
      else $error("pixel with room left did not take three bits");

endmodule

`default_nettype wire

// ===== hw/rtl/lsbe_embed.sv =====
// Combinational bit insertion into the red, green and blue LSBs.
`timescale 1ns / 1ps
`default_nettype none

module lsbe_embed (
   input  wire logic               [7:0] byte0,
   input  wire logic               [7:0] byte1,
   input  wire lsbe_pkg::plan_type       plan,
   input  wire logic               [7:0] pixel_red,
   input  wire logic               [7:0] pixel_green,
   input  wire logic               [7:0] pixel_blue,
   input  wire logic               [7:0] pixel_alpha,
   output      logic               [7:0] out_red,
   output      logic               [7:0] out_green,
   output      logic               [7:0] out_blue,
   output      logic               [7:0] out_alpha
);

   logic [15:0] word, shifted;
   logic [7:0]  chan_in  [3];
   logic [7:0]  chan_out [3];

   always_comb begin
      // bytes at or past the length read as the terminator
      word    = {plan.byte0_valid ? byte0 : lsbe_pkg::TERMINATOR,
                 plan.byte1_valid ? byte1 : lsbe_pkg::TERMINATOR};
      shifted = word << plan.bit_offset;
      chan_in[0] = pixel_red;
      chan_in[1] = pixel_green;
      chan_in[2] = pixel_blue;
      for (int k = 0; k < 3; k++) begin
         if (2'(k) < plan.bit_count) begin
            chan_out[k] = (chan_in[k] & lsbe_pkg::LSB_CLEAR) | {7'd0, shifted[15 - k]};
         end else begin
            chan_out[k] = chan_in[k];
         end
      end
      out_red   = chan_out[0];
      out_green = chan_out[1];
      out_blue  = chan_out[2];
      out_alpha = (plan.bit_count != 2'd0) ? lsbe_pkg::ALPHA_OPAQUE : pixel_alpha;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsb_text_embedder.sv =====
// Top level of the LSB text embedder: handshake, pipeline registers, result register.
//
//   channel | direction | handshake              | carries
//   --------+-----------+------------------------+-----------------------------------
//   req_    | in        | req_valid / req_ready  | op, message byte + first, RGBA pixel
//   rsp_    | out       | rsp_valid / rsp_ready  | embedded RGBA, bit count, flags
//
// One transaction per clock sustained while rsp_ready stays high; a pixel result
// is offered once it has passed the stage register (store read and pixel held)
// and then the result register.
// Load transactions give no result and complete in the cycle they are taken.
// Synchronous active-high reset clears length, bit position, overflow and valids;
// the message store itself is not cleared (only entries below the length are used).
// A stall on rsp_ready fills the stage register and then drops req_ready;
// loads are held off as well while that stage is full.
`timescale 1ns / 1ps
`default_nettype none

module lsb_text_embedder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_op,
   input  wire logic [7:0] req_message_byte,
   input  wire logic       req_message_first,
   input  wire logic [7:0] req_pixel_red,
   input  wire logic [7:0] req_pixel_green,
   input  wire logic [7:0] req_pixel_blue,
   input  wire logic [7:0] req_pixel_alpha,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_out_red,
   output      logic [7:0] rsp_out_green,
   output      logic [7:0] rsp_out_blue,
   output      logic [7:0] rsp_out_alpha,
   output      logic [1:0] rsp_bits_embedded,
   output      logic       rsp_message_done,
   output      logic       rsp_overflow_seen
);

   logic req_acc, load_acc, pixel_acc;
   logic stage_valid_ff, stage_valid_in;
   logic out_valid_ff, out_valid_in;
   logic stage_move;

   // pixel held alongside the store read
   logic [7:0] pix_red_ff, pix_green_ff, pix_blue_ff, pix_alpha_ff;

   lsbe_pkg::plan_type plan;
   logic [7:0] byte0, byte1;
   logic [7:0] emb_red, emb_green, emb_blue, emb_alpha;

   logic [7:0] out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   logic [1:0] out_bits_ff;
   logic       out_done_ff, out_ovf_ff;

   // stage advances into the result register when that is empty or draining
   assign stage_move = stage_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !stage_valid_ff || stage_move;
   assign req_acc    = req_valid && req_ready;
   assign load_acc   = req_acc && (req_op == lsbe_pkg::OP_LOAD);
   assign pixel_acc  = req_acc && (req_op == lsbe_pkg::OP_PIXEL);

   assign stage_valid_in = pixel_acc || (stage_valid_ff && !stage_move);
   assign out_valid_in   = stage_move || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_acc) begin
         pix_red_ff   <= req_pixel_red;
         pix_green_ff <= req_pixel_green;
         pix_blue_ff  <= req_pixel_blue;
         pix_alpha_ff <= req_pixel_alpha;
      end
   end

   lsbe_msg_ctrl u_msg_ctrl (
      .clock         (clock),
      .reset         (reset),
      .load_acc      (load_acc),
      .pixel_acc     (pixel_acc),
      .message_byte  (req_message_byte),
      .message_first (req_message_first),
      .plan          (plan),
      .byte0         (byte0),
      .byte1         (byte1)
   );

   lsbe_embed u_embed (
      .byte0       (byte0),
      .byte1       (byte1),
      .plan        (plan),
      .pixel_red   (pix_red_ff),
      .pixel_green (pix_green_ff),
      .pixel_blue  (pix_blue_ff),
      .pixel_alpha (pix_alpha_ff),
      .out_red     (emb_red),
      .out_green   (emb_green),
      .out_blue    (emb_blue),
      .out_alpha   (emb_alpha)
   );

   always_ff @(posedge clock) begin
      if (stage_move) begin
         out_red_ff   <= emb_red;
         out_green_ff <= emb_green;
         out_blue_ff  <= emb_blue;
         out_alpha_ff <= emb_alpha;
         out_bits_ff  <= plan.bit_count;
         out_done_ff  <= plan.done;
         out_ovf_ff   <= plan.overflow;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_red       = out_red_ff;
   assign rsp_out_green     = out_green_ff;
   assign rsp_out_blue      = out_blue_ff;
   assign rsp_out_alpha     = out_alpha_ff;
   assign rsp_bits_embedded = out_bits_ff;
   assign rsp_message_done  = out_done_ff;
   assign rsp_overflow_seen = out_ovf_ff;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> req_ready)
      else $error("request side stalled with empty stage");

   a_pixel_enters_stage: assert property (@(posedge clock) disable iff (reset)
      pixel_acc |=> stage_valid_ff)
      else $error("accepted pixel missing from stage");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      load_acc && !stage_valid_ff && !out_valid_ff |=> !stage_valid_ff && !out_valid_ff)
      else $error("load transaction produced a result");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for lsb_text_embedder: directed and random loads and pixels, checked in order.
`timescale 1ns / 1ps

module tb;

   localparam int ItemsTarget    = 1950;
   localparam int LongHoldCycles = 60;
   localparam int PauseInterval  = 400;

   // one request transaction as the sender offers it
   typedef struct packed {
      logic       op;
      logic [7:0] message_byte;
      logic       message_first;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } embed_request_type;

   // one pixel result, field order matches the rsp_ ports
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [1:0] bits_embedded;
      logic       message_done;
      logic       overflow_seen;
   } embed_pixel_type;

   // Keeps its own copy of the message store and bit position, works out each
   // pixel result as its request is accepted, and checks results in order.
   class embedding_scoreboard;
      logic [7:0]      message_bytes [lsbe_pkg::MaxMessageBytes];
      int unsigned     message_len = 0;
      int unsigned     bit_pos     = 0;
      logic            overflow    = 1'b0;
      embed_pixel_type expected_pixels [$];
      int              mismatches  = 0;

      task report_mismatch(string what);
         mismatches++;
         $display("%0t ns mismatch: %s", $time, what);
      endtask

      function void note_request(embed_request_type item);
         int unsigned     total;
         int              c;
         logic [7:0]      chan [3];
         embed_pixel_type want;
         if (item.op == lsbe_pkg::OP_LOAD) begin
            // restart clears everything before the byte is stored, even when full
            if (item.message_first) begin
               message_len = 0;
               bit_pos     = 0;
               overflow    = 1'b0;
            end
            if (message_len < lsbe_pkg::MaxMessageBytes) begin
               message_bytes[message_len] = item.message_byte;
               message_len++;
            end else begin
               overflow = 1'b1;
            end
         end else begin
            total   = (message_len + 1) * 8;
            chan[0] = item.red;
            chan[1] = item.green;
            chan[2] = item.blue;
            want.bits_embedded = 2'd0;
            for (c = 0; c < 3; c++) begin
               if (bit_pos < total) begin
                  // positions past the stored bytes fall in the zero terminator
                  chan[c][0] = (bit_pos / 8 < message_len) ?
                               message_bytes[bit_pos / 8][7 - bit_pos % 8] : 1'b0;
                  bit_pos++;
                  want.bits_embedded++;
               end
            end
            want.red           = chan[0];
            want.green         = chan[1];
            want.blue          = chan[2];
            want.alpha         = (want.bits_embedded != 2'd0) ?
                                 lsbe_pkg::ALPHA_OPAQUE : item.alpha;
            want.message_done  = (bit_pos >= total);
            want.overflow_seen = overflow;
            expected_pixels.push_back(want);
         end
      endfunction

      task check_pixel(embed_pixel_type got);
         embed_pixel_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %p", got));
            return;
         end
         want = expected_pixels[0];
         expected_pixels.delete(0);
         if (got.red !== want.red)
            report_mismatch($sformatf("red got %h want %h", got.red, want.red));
         if (got.green !== want.green)
            report_mismatch($sformatf("green got %h want %h", got.green, want.green));
         if (got.blue !== want.blue)
            report_mismatch($sformatf("blue got %h want %h", got.blue, want.blue));
         if (got.alpha !== want.alpha)
            report_mismatch($sformatf("alpha got %h want %h", got.alpha, want.alpha));
         if (got.bits_embedded !== want.bits_embedded)
            report_mismatch($sformatf("bits_embedded got %0d want %0d",
                                      got.bits_embedded, want.bits_embedded));
         if (got.message_done !== want.message_done)
            report_mismatch($sformatf("message_done got %b want %b",
                                      got.message_done, want.message_done));
         if (got.overflow_seen !== want.overflow_seen)
            report_mismatch($sformatf("overflow_seen got %b want %b",
                                      got.overflow_seen, want.overflow_seen));
      endtask
   endclass

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_op            = lsbe_pkg::OP_LOAD;
   logic [7:0] req_message_byte  = 8'h00;
   logic       req_message_first = 1'b0;
   logic [7:0] req_pixel_red     = 8'h00;
   logic [7:0] req_pixel_green   = 8'h00;
   logic [7:0] req_pixel_blue    = 8'h00;
   logic [7:0] req_pixel_alpha   = 8'h00;
   logic       rsp_ready         = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_alpha;
   logic [1:0] rsp_bits_embedded;
   logic       rsp_message_done;
   logic       rsp_overflow_seen;

   embedding_scoreboard sb;
   bit sender_steady = 1'b0;   // no gaps between request transactions while set
   int items_sent    = 0;

   lsb_text_embedder dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request; valid stays up with the payload held until the handshake.
   // Returns in the step of acceptance with valid still high, so the caller's next
   // drive in that step is the only one.
   task automatic send_item(embed_request_type item);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= item.op;
      req_message_byte  <= item.message_byte;
      req_message_first <= item.message_first;
      req_pixel_red     <= item.red;
      req_pixel_green   <= item.green;
      req_pixel_blue    <= item.blue;
      req_pixel_alpha   <= item.alpha;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
      items_sent++;
   endtask

   function automatic logic [7:0] any_channel();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // unused fields are randomised as well, the block must ignore them
   task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                             logic [7:0] alpha);
      send_item('{op: lsbe_pkg::OP_PIXEL, message_byte: 8'($urandom),
                  message_first: 1'($urandom), red: red, green: green, blue: blue,
                  alpha: alpha});
   endtask

   task automatic send_random_pixel();
      send_pixel(any_channel(), any_channel(), any_channel(), any_channel());
   endtask

   task automatic send_load(logic [7:0] message_byte, logic message_first);
      send_item('{op: lsbe_pkg::OP_LOAD, message_byte: message_byte,
                  message_first: message_first,
                  red: 8'($urandom), green: 8'($urandom), blue: 8'($urandom),
                  alpha: 8'($urandom)});
   endtask

   // sender goes quiet until every outstanding pixel result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_pixels.size() != 0) @(posedge clock);
   endtask

   // Result side: random stall before each transaction, steady stretches now and
   // then, and two long hold-offs so the pipeline fills and req_ready drops.
   initial begin : result_side
      int              stall;
      int              results_seen;
      bit              steady;
      embed_pixel_type got;
      results_seen = 0;
      steady       = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (results_seen % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         stall = steady ? 0 : $urandom_range(0, 7);
         if (results_seen == 250 || results_seen == 900)
            stall = LongHoldCycles;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha,
                rsp_bits_embedded, rsp_message_done, rsp_overflow_seen};
         sb.check_pixel(got);
         results_seen++;
      end
   end

   initial begin : stimulus
      int i;
      int p;
      int kind;
      int len;
      int pixels;
      int split;
      int long_msgs;
      int next_pause;
      sb = new;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // nothing loaded yet: only the eight terminator bits go out
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'hFF, 8'h5A);   // last two bits, done after this
      send_pixel(8'hA5, 8'h5A, 8'h3C, 8'h12);   // passes unchanged

      // two bytes, then a third appended part way through embedding
      send_load(8'hFF, 1'b1);
      send_load(8'h01, 1'b0);
      for (i = 0; i < 4; i++)
         send_pixel(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, i[0] ? 8'hFF : 8'h00,
                    i[0] ? 8'h80 : 8'h7F);
      send_load(8'h7E, 1'b0);
      for (i = 0; i < 8; i++)
         send_pixel(i[0] ? 8'h00 : 8'hFF, i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF,
                    i[0] ? 8'h7F : 8'h80);
      send_load(8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
      wait_for_results();

      // Random part: mostly whole messages followed by enough pixels to use them
      // up, some cut short, some with a byte appended mid-way; a little noise and
      // a couple of messages long enough to fill the store and drop bytes.
      long_msgs  = 0;
      next_pause = PauseInterval;
      while (items_sent < ItemsTarget) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         if (items_sent >= next_pause) begin
            wait_for_results();
            next_pause += PauseInterval;
         end
         kind = $urandom_range(0, 19);
         if (long_msgs == 0 && items_sent > 900)
            kind = 2;
         if (kind == 2 && long_msgs >= 2)
            kind = 5;
         case (kind)
            0, 1: begin
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 1) == 0)
                     send_load(8'($urandom), $urandom_range(0, 7) == 0);
                  else
                     send_random_pixel();
               end
            end
            2: begin
               // straddles the store size: exactly full, and some bytes dropped
               len = $urandom_range(lsbe_pkg::MaxMessageBytes - 2,
                                    lsbe_pkg::MaxMessageBytes + 4);
               for (i = 0; i < len; i++)
                  send_load(8'($urandom), i == 0);
               repeat ($urandom_range(20, 50)) send_random_pixel();
               long_msgs++;
            end
            default: begin
               len    = $urandom_range(1, 10);
               pixels = ((len + 1) * 8 + 2) / 3;
               if ($urandom_range(0, 4) == 0)
                  pixels = $urandom_range(0, pixels);
               else
                  pixels += $urandom_range(0, 3);
               split = ($urandom_range(0, 3) == 0) ? $urandom_range(0, pixels) : -1;
               for (i = 0; i < len; i++)
                  send_load(8'($urandom), i == 0);
               for (p = 0; p < pixels; p++) begin
                  if (p == split)
                     send_load(8'($urandom), 1'b0);
                  send_random_pixel();
               end
            end
         endcase
      end

      sender_steady = 1'b0;
      wait_for_results();
      // anything arriving now has no request behind it
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
